[rtl/haar_parity_watermark_embed_assert.svh]
// Assertion macros for the Haar parity watermark embedder
`ifndef HAAR_PARITY_WATERMARK_EMBED_ASSERT_SVH
`define HAAR_PARITY_WATERMARK_EMBED_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPWE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hpwe check failed");
`define HPWE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hpwe check failed");
`else
`define HPWE_ASSERT_SAME(lbl, ante, cons)
`define HPWE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/hpwe_pkg.sv]
// Package: register indexes, field widths and beat types for the watermark embedder
package hpwe_pkg;

   localparam int BLOCK_DIM_MAX = 1024;
   localparam int COORD_W       = $clog2(BLOCK_DIM_MAX);
   localparam int PIX_W         = 8;
   localparam int MSG_W         = 64;
   localparam int COUNT_W       = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;

   localparam logic [COUNT_W-1:0] LENGTH_RESET = 8'd0;
   localparam logic [PIX_W-1:0]   ALPHA_RESET  = 8'd16;
   localparam logic [COORD_W-1:0] START_RESET  = 10'd10;

   typedef enum logic [2:0] {
      REG_MSG_HIGH  = 3'd0,
      REG_MSG_LOW   = 3'd1,
      REG_MSG_LEN   = 3'd2,
      REG_ALPHA     = 3'd3,
      REG_START_ROW = 3'd4,
      REG_START_COL = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               frame_start;
      logic [COORD_W-1:0] block_row;
      logic [COORD_W-1:0] block_col;
      logic [PIX_W-1:0]   pix_tl;
      logic [PIX_W-1:0]   pix_tr;
      logic [PIX_W-1:0]   pix_bl;
      logic [PIX_W-1:0]   pix_br;
   } req_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_tl;
      logic [PIX_W-1:0] out_tr;
      logic [PIX_W-1:0] out_bl;
      logic [PIX_W-1:0] out_br;
      logic             bit_slot;
      logic             adjusted;
   } rsp_beat_type;

   // 16*p + a, rounded half to even back to integer, saturated at 255
   function automatic logic [PIX_W-1:0] add_round_sat(input logic [PIX_W-1:0] pix,
                                                      input logic [PIX_W-1:0] add);
      logic [PIX_W+4:0] v;
      logic [PIX_W:0]   q;
      logic [3:0]       r;
      logic             inc;
      logic [PIX_W+1:0] qr;
      v   = {1'b0, pix, 4'b0000} + {5'b00000, add};
      q   = v[PIX_W+4:4];
      r   = v[3:0];
      inc = (r > 4'd8) || ((r == 4'd8) && q[0]);
      qr  = {1'b0, q} + {{(PIX_W+1){1'b0}}, inc};
      if (qr > (PIX_W+2)'(255)) begin
         add_round_sat = 8'hFF;
      end else begin
         add_round_sat = qr[PIX_W-1:0];
      end
   endfunction

endpackage

[rtl/haar_parity_watermark_embed.sv]
// Top level: Haar LL parity watermark embedder for a stream of 2x2 luma blocks
// Throughput: one block per cycle unless rsp_tready stalls it; input register, one pass of logic, result register.
// The bit counter is the only state carried between blocks and advances as a block with
// a bit slot leaves the input register. Synchronous active-high reset empties the pipeline,
// clears the bit counter and returns the configuration registers to their documented defaults.
`include "haar_parity_watermark_embed_assert.svh"

module haar_parity_watermark_embed #(
   parameter int MAX_MESSAGE_BITS = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // block_row, block_col, pix_tl, pix_tr, pix_bl, pix_br, pad
   input  logic        req_tuser,   // frame_start
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_tl, out_tr, out_bl, out_br
   output logic [1:0]  rsp_tuser,   // bit_slot, adjusted
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [hpwe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hpwe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hpwe_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [hpwe_pkg::COUNT_W-1:0] LEN_CAP = (hpwe_pkg::COUNT_W)'(MAX_MESSAGE_BITS);

   // configuration
   logic [hpwe_pkg::MSG_W-1:0]   msg_high_ff;
   logic [hpwe_pkg::MSG_W-1:0]   msg_low_ff;
   logic [hpwe_pkg::COUNT_W-1:0] msg_len_ff;
   logic [hpwe_pkg::PIX_W-1:0]   alpha_ff;
   logic [hpwe_pkg::COORD_W-1:0] start_row_ff;
   logic [hpwe_pkg::COORD_W-1:0] start_col_ff;

   logic                    csr_wr;
   hpwe_pkg::csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = hpwe_pkg::csr_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_high_ff  <= '0;
         msg_low_ff   <= '0;
         msg_len_ff   <= hpwe_pkg::LENGTH_RESET;
         alpha_ff     <= hpwe_pkg::ALPHA_RESET;
         start_row_ff <= hpwe_pkg::START_RESET;
         start_col_ff <= hpwe_pkg::START_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            hpwe_pkg::REG_MSG_HIGH:  msg_high_ff  <= csr_pwdata;
            hpwe_pkg::REG_MSG_LOW:   msg_low_ff   <= csr_pwdata;
            hpwe_pkg::REG_MSG_LEN:   msg_len_ff   <= csr_pwdata[hpwe_pkg::COUNT_W-1:0];
            hpwe_pkg::REG_ALPHA:     alpha_ff     <= csr_pwdata[hpwe_pkg::PIX_W-1:0];
            hpwe_pkg::REG_START_ROW: start_row_ff <= csr_pwdata[hpwe_pkg::COORD_W-1:0];
            hpwe_pkg::REG_START_COL: start_col_ff <= csr_pwdata[hpwe_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         hpwe_pkg::REG_MSG_HIGH:  csr_prdata = msg_high_ff;
         hpwe_pkg::REG_MSG_LOW:   csr_prdata = msg_low_ff;
         hpwe_pkg::REG_MSG_LEN:   csr_prdata = {56'd0, msg_len_ff};
         hpwe_pkg::REG_ALPHA:     csr_prdata = {56'd0, alpha_ff};
         hpwe_pkg::REG_START_ROW: csr_prdata = {54'd0, start_row_ff};
         hpwe_pkg::REG_START_COL: csr_prdata = {54'd0, start_col_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic                  in_valid_ff;
   hpwe_pkg::req_beat_type in_beat_ff;
   logic                  out_valid_ff;
   hpwe_pkg::rsp_beat_type out_beat_ff;
   hpwe_pkg::rsp_beat_type out_beat_in;
   logic [hpwe_pkg::COUNT_W-1:0] bits_done_ff;
   logic [hpwe_pkg::COUNT_W-1:0] bits_done_in;
   logic                  advance;
   logic                  req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bits_done_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               bits_done_ff <= bits_done_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.frame_start <= req_tuser;
         in_beat_ff.block_row   <= req_tdata[9:0];
         in_beat_ff.block_col   <= req_tdata[19:10];
         in_beat_ff.pix_tl      <= req_tdata[27:20];
         in_beat_ff.pix_tr      <= req_tdata[35:28];
         in_beat_ff.pix_bl      <= req_tdata[43:36];
         in_beat_ff.pix_br      <= req_tdata[51:44];
      end
      if (advance && in_valid_ff) begin
         out_beat_ff <= out_beat_in;
      end
   end

   // embedding pass
   logic [hpwe_pkg::COUNT_W-1:0] count_cur;
   logic [hpwe_pkg::COUNT_W-1:0] len_eff;
   logic [hpwe_pkg::PIX_W+1:0]   pix_sum;
   logic [hpwe_pkg::PIX_W+2:0]   sum_rnd;
   logic [5:0]                   bit_pos;
   logic                         msg_bit;
   logic                         slot;
   logic                         adjust;

   always_comb begin
      count_cur = in_beat_ff.frame_start ? '0 : bits_done_ff;
      len_eff   = (msg_len_ff > LEN_CAP) ? LEN_CAP : msg_len_ff;
      slot      = (in_beat_ff.block_row >= start_row_ff) &&
                  (in_beat_ff.block_col >= start_col_ff) && (count_cur < len_eff);
      pix_sum   = {2'b00, in_beat_ff.pix_tl} + {2'b00, in_beat_ff.pix_tr} +
                  {2'b00, in_beat_ff.pix_bl} + {2'b00, in_beat_ff.pix_br};
      sum_rnd   = {1'b0, pix_sum} + 11'd2;
      bit_pos   = ~count_cur[5:0];
      msg_bit   = count_cur[6] ? msg_low_ff[bit_pos] : msg_high_ff[bit_pos];
      adjust    = slot && (sum_rnd[2] != msg_bit);
      bits_done_in = slot ? count_cur + 8'd1 : count_cur;

      out_beat_in.bit_slot = slot;
      out_beat_in.adjusted = adjust;
      if (adjust) begin
         out_beat_in.out_tl = hpwe_pkg::add_round_sat(in_beat_ff.pix_tl, alpha_ff);
         out_beat_in.out_tr = hpwe_pkg::add_round_sat(in_beat_ff.pix_tr, alpha_ff);
         out_beat_in.out_bl = hpwe_pkg::add_round_sat(in_beat_ff.pix_bl, alpha_ff);
         out_beat_in.out_br = hpwe_pkg::add_round_sat(in_beat_ff.pix_br, alpha_ff);
      end else begin
         out_beat_in.out_tl = in_beat_ff.pix_tl;
         out_beat_in.out_tr = in_beat_ff.pix_tr;
         out_beat_in.out_bl = in_beat_ff.pix_bl;
         out_beat_in.out_br = in_beat_ff.pix_br;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_beat_ff.out_br, out_beat_ff.out_bl,
                        out_beat_ff.out_tr, out_beat_ff.out_tl};
   assign rsp_tuser  = {out_beat_ff.adjusted, out_beat_ff.bit_slot};

   `HPWE_ASSERT_SAME(a_adj_needs_slot, out_valid_ff && out_beat_ff.adjusted, out_beat_ff.bit_slot)
   `HPWE_ASSERT_SAME(a_stall_only_full, !req_tready, in_valid_ff && out_valid_ff)
   `HPWE_ASSERT_NEXT(a_slot_counts, in_valid_ff && advance && slot, bits_done_ff != '0)
   `HPWE_ASSERT_NEXT(a_idle_count_holds,
                     in_valid_ff && advance && !slot && !in_beat_ff.frame_start,
                     $stable(bits_done_ff))

endmodule
